// ===== hw/rtl/swm_pkg.sv =====
// Shared types and constants for the spectral window multiply unit.
// Holds window codes, register indexes, CORDIC constants and the coefficient write port type.
// No dependencies.
package swm_pkg;

   // Coefficient format: unsigned Q1.15
   localparam int COEF_BITS = 16;
   localparam int COEF_FRAC = COEF_BITS - 1;
   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC);

   // Frame length register
   localparam int LEN_W   = 11;
   localparam int LEN_MAX = (1 << LEN_W) - 1;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes (paddr[2])
   localparam logic REG_WINDOW_TYPE  = 1'b0;
   localparam logic REG_FRAME_LENGTH = 1'b1;

   // Window type codes; the unused code acts as rectangular
   localparam logic [1:0] WIN_RECT    = 2'd0;
   localparam logic [1:0] WIN_HAMMING = 2'd1;
   localparam logic [1:0] WIN_HANN    = 2'd2;

   // CORDIC, Q2.30, angles in 2^-32 turns
   localparam int CORDIC_W     = 32;
   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = 5;
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;
   localparam logic signed [CORDIC_W-1:0] COS_ONE   = 32'sd1073741824;

   // Hamming: (54*2^30 + 50*2^15 - 46c) / 2^15, then divide by 100
   localparam int HAM_NUM_W = 40;
   localparam logic signed [HAM_NUM_W-1:0] HAM_BASE = 40'sd57983696896;
   localparam logic signed [HAM_NUM_W-1:0] HAM_SLOPE = 40'sd46;
   localparam int HAM_V_W = 22;
   localparam int HAM_RECIP_W = 23;
   localparam logic [HAM_RECIP_W-1:0] HAM_RECIP = 23'd5368710;   // ceil(2^29 / 100)
   localparam int HAM_RECIP_SHIFT = 29;
   localparam int HAM_PROD_W = HAM_V_W + HAM_RECIP_W;

   // Hann: (2^30 - c + 2^15) >> 16
   localparam int HANN_NUM_W = 33;
   localparam logic signed [HANN_NUM_W-1:0] HANN_BASE = 33'sd1073774592;

   // Write port from the coefficient generator into the table
   typedef struct packed {
      logic                 en;
      logic [LEN_W-1:0]     addr;
      logic [COEF_BITS-1:0] data;
   } coef_wr_type;

   // Arctangent of 2^-i in 2^-32 turns
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
      logic signed [CORDIC_W-1:0] a;
      case (i)
         5'd0:    a = 32'sd536870912;
         5'd1:    a = 32'sd316933406;
         5'd2:    a = 32'sd167458907;
         5'd3:    a = 32'sd85004756;
         5'd4:    a = 32'sd42667331;
         5'd5:    a = 32'sd21354465;
         5'd6:    a = 32'sd10679838;
         5'd7:    a = 32'sd5340245;
         5'd8:    a = 32'sd2670163;
         5'd9:    a = 32'sd1335087;
         5'd10:   a = 32'sd667544;
         5'd11:   a = 32'sd333772;
         5'd12:   a = 32'sd166886;
         5'd13:   a = 32'sd83443;
         5'd14:   a = 32'sd41721;
         5'd15:   a = 32'sd20861;
         5'd16:   a = 32'sd10430;
         5'd17:   a = 32'sd5215;
         5'd18:   a = 32'sd2608;
         5'd19:   a = 32'sd1304;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== hw/rtl/swm_coef_gen.sv =====
// Coefficient generator: fills the window table after a configuration write.
// Serial divider for the phase step, iterative CORDIC, Hamming/Hann scaling.
// Depends on swm_pkg.
module swm_coef_gen (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                win_type,
   input  logic [swm_pkg::LEN_W-1:0] frame_len,
   output logic                      busy,
   output swm_pkg::coef_wr_type      coef_wr
);
   import swm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD,
      ST_ROTATE,
      ST_POST,
      ST_MUL,
      ST_WRITE,
      ST_FLAT
   } state_type;

   localparam int DIV_STEPS = 33;   // quotient bits of 2^32 / (L-1)
   localparam int DIV_CNT_W = 6;

   state_type                   state_ff, state_in;
   logic [1:0]                  type_ff, type_in;
   logic [LEN_W-1:0]            dsr_ff, dsr_in;       // L-1
   logic [LEN_W-1:0]            n_ff, n_in;
   logic [DIV_CNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic [LEN_W-1:0]            div_rem_ff, div_rem_in; // phase step remainder when done
   logic [31:0]                 div_q_ff, div_q_in;     // phase step quotient when done
   logic [31:0]                 acc_q_ff, acc_q_in;
   logic [LEN_W-1:0]            acc_r_ff, acc_r_in;
   logic signed [CORDIC_W-1:0]  cx_ff, cx_in;
   logic signed [CORDIC_W-1:0]  cy_ff, cy_in;
   logic signed [CORDIC_W-1:0]  cz_ff, cz_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [1:0]                  quad_ff, quad_in;
   logic [HAM_V_W-1:0]          ham_v_ff, ham_v_in;
   logic [COEF_BITS-1:0]        hann_w_ff, hann_w_in;
   logic [HAM_PROD_W-1:0]       ham_prod_ff, ham_prod_in;

   // Datapath terms
   logic [LEN_W:0]              trial;
   logic                        qbit;
   logic signed [CORDIC_W-1:0]  dx, dy;
   logic signed [CORDIC_W-1:0]  c_raw, c_clamp;
   logic signed [HAM_NUM_W-1:0] ham_num;
   logic signed [HANN_NUM_W-1:0] hann_num;
   logic [LEN_W:0]              r_sum;
   logic                        r_wrap;
   logic [COEF_BITS-1:0]        ham_q, coef_pick, coef_val;
   logic                        windowed;

   // Restoring division step: dividend is 2^32, one bit per cycle
   assign trial = {div_rem_ff, (div_cnt_ff == '0)};
   assign qbit  = (trial >= {1'b0, dsr_ff});

   // CORDIC micro-rotation
   assign dx = cy_ff >>> step_ff;
   assign dy = cx_ff >>> step_ff;

   // Quadrant fold and clamp of the cosine
   always_comb begin
      unique case (quad_ff)
         2'd0: c_raw = cx_ff;
         2'd1: c_raw = -cy_ff;
         2'd2: c_raw = -cx_ff;
         2'd3: c_raw = cy_ff;
      endcase
      if (c_raw > COS_ONE) begin
         c_clamp = COS_ONE;
      end else if (c_raw < -COS_ONE) begin
         c_clamp = -COS_ONE;
      end else begin
         c_clamp = c_raw;
      end
   end

   assign ham_num  = HAM_BASE - HAM_NUM_W'(c_clamp) * HAM_SLOPE;
   assign hann_num = HANN_BASE - HANN_NUM_W'(c_clamp);

   // Final coefficient
   assign ham_q     = ham_prod_ff[HAM_RECIP_SHIFT +: COEF_BITS];
   assign coef_pick = (type_ff == WIN_HAMMING) ? ham_q : hann_w_ff;
   assign coef_val  = (coef_pick > COEF_ONE) ? COEF_ONE : coef_pick;

   // Phase accumulator: p(n+1) = p(n) + 2^32/(L-1), carried exactly
   assign r_sum  = {1'b0, acc_r_ff} + {1'b0, div_rem_ff};
   assign r_wrap = (r_sum >= {1'b0, dsr_ff});

   assign windowed = (win_type == WIN_HAMMING) || (win_type == WIN_HANN);

   // Next state
   always_comb begin
      state_in    = state_ff;
      type_in     = type_ff;
      dsr_in      = dsr_ff;
      n_in        = n_ff;
      div_cnt_in  = div_cnt_ff;
      div_rem_in  = div_rem_ff;
      div_q_in    = div_q_ff;
      acc_q_in    = acc_q_ff;
      acc_r_in    = acc_r_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      step_in     = step_ff;
      quad_in     = quad_ff;
      ham_v_in    = ham_v_ff;
      hann_w_in   = hann_w_ff;
      ham_prod_in = ham_prod_ff;

      if (start) begin
         type_in    = win_type;
         dsr_in     = frame_len - LEN_W'(1);
         n_in       = '0;
         div_cnt_in = '0;
         div_rem_in = '0;
         div_q_in   = '0;
         state_in   = windowed ? ST_DIV : ST_FLAT;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_DIV: begin
               div_rem_in = qbit ? LEN_W'(trial - {1'b0, dsr_ff}) : trial[LEN_W-1:0];
               div_q_in   = {div_q_ff[30:0], qbit};
               div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
                  acc_q_in = '0;
                  acc_r_in = '0;
                  state_in = ST_LOAD;
               end
            end
            ST_LOAD: begin
               cx_in    = CORDIC_X0;
               cy_in    = '0;
               cz_in    = {2'b00, acc_q_ff[29:0]};
               quad_in  = acc_q_ff[31:30];
               step_in  = '0;
               state_in = ST_ROTATE;
            end
            ST_ROTATE: begin
               if (!cz_ff[CORDIC_W-1]) begin
                  cx_in = cx_ff - dx;
                  cy_in = cy_ff + dy;
                  cz_in = cz_ff - atan_turn(step_ff);
               end else begin
                  cx_in = cx_ff + dx;
                  cy_in = cy_ff - dy;
                  cz_in = cz_ff + atan_turn(step_ff);
               end
               step_in = step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_in = ST_POST;
               end
            end
            ST_POST: begin
               ham_v_in  = ham_num[COEF_FRAC +: HAM_V_W];
               hann_w_in = hann_num[COEF_FRAC + 1 +: COEF_BITS];
               state_in  = ST_MUL;
            end
            ST_MUL: begin
               ham_prod_in = HAM_PROD_W'(ham_v_ff) * HAM_PROD_W'(HAM_RECIP);
               state_in    = ST_WRITE;
            end
            ST_WRITE: begin
               acc_r_in = r_wrap ? LEN_W'(r_sum - {1'b0, dsr_ff}) : r_sum[LEN_W-1:0];
               acc_q_in = acc_q_ff + div_q_ff + 32'(r_wrap);
               n_in     = n_ff + LEN_W'(1);
               state_in = (n_ff == dsr_ff) ? ST_IDLE : ST_LOAD;
            end
            ST_FLAT: begin
               n_in     = n_ff + LEN_W'(1);
               state_in = (n_ff == dsr_ff) ? ST_IDLE : ST_FLAT;
            end
         endcase
      end
   end

   // State and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      type_ff     <= type_in;
      dsr_ff      <= dsr_in;
      n_ff        <= n_in;
      div_cnt_ff  <= div_cnt_in;
      div_rem_ff  <= div_rem_in;
      div_q_ff    <= div_q_in;
      acc_q_ff    <= acc_q_in;
      acc_r_ff    <= acc_r_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      step_ff     <= step_in;
      quad_ff     <= quad_in;
      ham_v_ff    <= ham_v_in;
      hann_w_ff   <= hann_w_in;
      ham_prod_ff <= ham_prod_in;
   end

   // Table write port
   always_comb begin
      coef_wr.en   = (state_ff == ST_WRITE) || (state_ff == ST_FLAT);
      coef_wr.addr = n_ff;
      coef_wr.data = (state_ff == ST_FLAT) ? COEF_ONE : coef_val;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hw/rtl/swm_datapath.sv =====
// Sample datapath: coefficient table, position counter and multiply pipeline.
// Table read, product, round/saturate into the output word register.
// Depends on swm_pkg.
module swm_datapath #(
   parameter int MAX_FRAME   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic                          fill_busy,
   input  logic [swm_pkg::LEN_W-1:0]     frame_len,
   input  swm_pkg::coef_wr_type          coef_wr,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_windowed_sample,
   output logic                          rsp_last_in_frame
);
   import swm_pkg::*;

   localparam int IDX_W  = $clog2(MAX_FRAME);
   localparam int PROD_W = SAMPLE_BITS + COEF_BITS + 1;
   localparam logic signed [PROD_W:0] RND_HALF = (PROD_W + 1)'(64'sd1 <<< (COEF_FRAC - 1));
   localparam logic signed [PROD_W:0] SAT_MAX  =
      (PROD_W + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [PROD_W:0] SAT_MIN  = -SAT_MAX - (PROD_W + 1)'(1);

   // Coefficient table
   logic [COEF_BITS-1:0] coef_mem [MAX_FRAME];

   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          v1_ff, v1_in;
   logic signed [SAMPLE_BITS-1:0] s1_ff, s1_in;
   logic                          last1_ff, last1_in;
   logic [COEF_BITS-1:0]          coef1_ff;
   logic                          v2_ff, v2_in;
   logic signed [PROD_W-1:0]      prod2_ff, prod2_in;
   logic                          last2_ff, last2_in;
   logic                          out_v_ff, out_v_in;
   logic signed [SAMPLE_BITS-1:0] out_s_ff, out_s_in;
   logic                          out_last_ff, out_last_in;

   logic                          en_out, en2, en1, accept, idx_last;
   logic signed [PROD_W:0]        rounded, shifted;

   // Stage enables: each stage moves when the next one is free or moving
   assign en_out    = !out_v_ff || !rsp_stall;
   assign en2       = !v2_ff || en_out;
   assign en1       = !v1_ff || en2;
   assign accept    = req_valid && en1 && !fill_busy;
   assign req_stall = !en1 || fill_busy;

   // Frame position
   assign idx_last = (32'(idx_ff) == 32'(frame_len) - 32'd1);

   always_comb begin
      idx_in = idx_ff;
      if (restart) begin
         idx_in = '0;
      end else if (accept) begin
         idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   // Stage 1: table read
   assign v1_in    = en1 ? accept : v1_ff;
   assign s1_in    = accept ? req_sample : s1_ff;
   assign last1_in = accept ? idx_last : last1_ff;

   always_ff @(posedge clock) begin
      if (coef_wr.en) begin
         coef_mem[IDX_W'(coef_wr.addr)] <= coef_wr.data;
      end
      if (accept) begin
         coef1_ff <= coef_mem[idx_ff];
      end
   end

   // Stage 2: product
   assign v2_in    = en2 ? v1_ff : v2_ff;
   assign prod2_in = en2 ? PROD_W'(s1_ff) * PROD_W'($signed({1'b0, coef1_ff})) : prod2_ff;
   assign last2_in = en2 ? last1_ff : last2_ff;

   // Output word: round half up, floor shift, saturate
   assign rounded = (PROD_W + 1)'(prod2_ff) + RND_HALF;
   assign shifted = rounded >>> COEF_FRAC;

   always_comb begin
      out_v_in    = out_v_ff;
      out_s_in    = out_s_ff;
      out_last_in = out_last_ff;
      if (en_out) begin
         out_v_in    = v2_ff;
         out_last_in = last2_ff;
         if (shifted > SAT_MAX) begin
            out_s_in = SAT_MAX[SAMPLE_BITS-1:0];
         end else if (shifted < SAT_MIN) begin
            out_s_in = SAT_MIN[SAMPLE_BITS-1:0];
         end else begin
            out_s_in = shifted[SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         out_v_ff <= out_v_in;
      end
      s1_ff       <= s1_in;
      last1_ff    <= last1_in;
      prod2_ff    <= prod2_in;
      last2_ff    <= last2_in;
      out_s_ff    <= out_s_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_windowed_sample = out_s_ff;
   assign rsp_last_in_frame   = out_last_ff;

endmodule

// ===== hw/rtl/spectral_window_multiply_unit.sv =====
// Spectral window multiply unit: top level with the register port.
// Instantiates swm_coef_gen and swm_datapath; depends on swm_pkg.
//
// Usage:
//  - req channel: one signed sample word per accepted cycle (req_valid high,
//    req_stall low). rsp channel: windowed sample plus last-in-frame flag.
//  - Registers: window_type at byte 0x0, frame_length at 0x4, written with an
//    APB setup/access pair; pready is always high, reads return the value.
//  - Each register write rebuilds the coefficient table and restarts the frame
//    position at 0. req_stall stays high while the table is rebuilt: a
//    rectangular table is filled with unity; Hamming/Hann run the phase-step
//    divider, then pass each entry through the 20-step CORDIC loop.
//  - Pipeline: an accepted sample passes the table read, product and output
//    word registers to rsp. Throughput: one sample per cycle unless rsp stalls
//    or a rebuild runs, set by the single table read port.
//  - When rsp is stalled, the two internal stages keep filling, so up to three
//    words are held before req_stall rises.
//  - Reset (synchronous): window_type rectangular, frame_length MAX_FRAME,
//    pipeline empty. The table holds no defined data until the first write.
module spectral_window_multiply_unit #(
   parameter int MAX_FRAME   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_windowed_sample,
   output logic                               rsp_last_in_frame,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import swm_pkg::*;

   localparam logic [LEN_W-1:0] LEN_RESET =
      (MAX_FRAME > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(MAX_FRAME);

   logic [1:0]       win_type_ff, win_type_in;
   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic             start_ff;
   logic             csr_wr;
   logic [LEN_W-1:0] eff_len;
   logic             gen_busy;
   coef_wr_type      coef_wr;

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      win_type_in  = win_type_ff;
      frame_len_in = frame_len_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_WINDOW_TYPE:  win_type_in  = pwdata[1:0];
            REG_FRAME_LENGTH: frame_len_in = pwdata[LEN_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WINDOW_TYPE:  prdata = CSR_DATA_W'(win_type_ff);
         REG_FRAME_LENGTH: prdata = CSR_DATA_W'(frame_len_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_type_ff  <= WIN_RECT;
         frame_len_ff <= LEN_RESET;
         start_ff     <= 1'b0;
      end else begin
         win_type_ff  <= win_type_in;
         frame_len_ff <= frame_len_in;
         start_ff     <= csr_wr;
      end
   end

   // Effective frame length: clamp to 2..MAX_FRAME
   always_comb begin
      if (frame_len_ff < LEN_W'(2)) begin
         eff_len = LEN_W'(2);
      end else if (32'(frame_len_ff) > 32'(MAX_FRAME)) begin
         eff_len = LEN_RESET;
      end else begin
         eff_len = frame_len_ff;
      end
   end

   swm_coef_gen u_coef_gen (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .win_type  (win_type_ff),
      .frame_len (eff_len),
      .busy      (gen_busy),
      .coef_wr   (coef_wr)
   );

   swm_datapath #(
      .MAX_FRAME   (MAX_FRAME),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .restart             (start_ff),
      .fill_busy           (gen_busy || start_ff),
      .frame_len           (eff_len),
      .coef_wr             (coef_wr),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_windowed_sample (rsp_windowed_sample),
      .rsp_last_in_frame   (rsp_last_in_frame)
   );

`ifndef SYNTH
   // A register write blocks the input side on the next cycle
   a_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> req_stall)
      else $error("input not blocked after register write");

   // Table writes stay inside the configured frame
   a_fill_in_frame: assert property (@(posedge clock) disable iff (reset)
      (coef_wr.en && !start_ff) |-> (coef_wr.addr < eff_len))
      else $error("table write beyond frame length");

   // Back-to-back table writes walk the entries in order
   a_fill_in_order: assert property (@(posedge clock) disable iff (reset)
      (coef_wr.en && !start_ff) |=>
         (!coef_wr.en || start_ff || (coef_wr.addr == $past(coef_wr.addr) + LEN_W'(1))))
      else $error("table writes out of order");
`endif

endmodule

// ===== tb/sv/swm_window_checker.sv =====
`timescale 1ns / 100ps
// Checker for spectral_window_multiply_unit: watches the sample, result and register ports,
// predicts each windowed word and compares it. Depends on swm_pkg.
module swm_window_checker #(
   parameter int MAX_FRAME   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0]     rsp_windowed_sample,
   input  logic                              rsp_last_in_frame,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]    pwdata,
   input  logic [swm_pkg::CSR_DATA_W-1:0]    prdata,
   input  logic                              pready,
   output int                                pending,
   output int                                fail_count
);

   localparam int CF = swm_pkg::COEF_FRAC;
   localparam longint Q30 = 64'sd1073741824;
   localparam longint COEF_UNIT = 64'sd1 <<< (30 - CF);
   localparam longint COEF_FULL = 64'sd1 <<< CF;
   localparam longint ROUND_HALF = 64'sd1 <<< (CF - 1);
   localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;
   localparam longint CORDIC_START = 64'sd652032874;
   localparam logic [swm_pkg::LEN_W-1:0] LEN_AT_RESET = swm_pkg::LEN_W'(MAX_FRAME);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] windowed;
      logic                          last;
   } windowed_word_type;

   windowed_word_type expected_words[$];
   windowed_word_type head_word;
   logic [1:0]     window_shape;
   logic [swm_pkg::LEN_W-1:0] frame_len_reg;
   int unsigned    frame_pos;
   int unsigned    eff_len;
   logic [swm_pkg::COEF_BITS-1:0] coef;
   longint         prod;
   int             mismatches = 0;

   // arctangent of 2^-k, in 2^-32 turns
   function automatic longint arctan_turns(input int k);
      case (k)
         0:  return 536870912;
         1:  return 316933406;
         2:  return 167458907;
         3:  return 85004756;
         4:  return 42667331;
         5:  return 21354465;
         6:  return 10679838;
         7:  return 5340245;
         8:  return 2670163;
         9:  return 1335087;
         10: return 667544;
         11: return 333772;
         12: return 166886;
         13: return 83443;
         14: return 41721;
         15: return 20861;
         16: return 10430;
         17: return 5215;
         18: return 2608;
         19: return 1304;
         default: return 0;
      endcase
   endfunction

   // window coefficient for position n of a frame of len samples, Q1.15
   function automatic logic [swm_pkg::COEF_BITS-1:0] window_coef(input logic [1:0] shape,
                                                                 input int unsigned n,
                                                                 input int unsigned len);
      longint unsigned turn;
      longint x, y, z, dx, dy, c, w;
      if (shape != swm_pkg::WIN_HAMMING && shape != swm_pkg::WIN_HANN)
         return COEF_FULL[swm_pkg::COEF_BITS-1:0];
      turn = 64'(n);
      turn = ((turn << 32) / 64'(len - 1)) & 64'hFFFF_FFFF;
      z = turn & 64'h3FFF_FFFF;
      x = CORDIC_START;
      y = 0;
      // rotate the in-quadrant remainder; arithmetic shifts floor
      for (int k = 0; k < swm_pkg::CORDIC_STEPS; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_turns(k);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_turns(k);
         end
      end
      case (turn[31:30])
         2'd0:    c = x;
         2'd1:    c = -y;
         2'd2:    c = -x;
         default: c = y;
      endcase
      if (c > Q30) c = Q30;
      if (c < -Q30) c = -Q30;
      if (shape == swm_pkg::WIN_HAMMING)
         w = (54 * Q30 - 46 * c + 50 * COEF_UNIT) / (100 * COEF_UNIT);
      else
         w = (Q30 - c + COEF_UNIT) >>> (31 - CF);
      if (w < 0) w = 0;
      if (w > COEF_FULL) w = COEF_FULL;
      return w[swm_pkg::COEF_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         window_shape = swm_pkg::WIN_RECT;
         frame_len_reg = LEN_AT_RESET;
         frame_pos = 0;
         expected_words.delete();
      end else begin
         // register port: a write restarts the frame, a read must echo the register
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == swm_pkg::REG_WINDOW_TYPE)
                  window_shape = pwdata[1:0];
               else
                  frame_len_reg = pwdata[swm_pkg::LEN_W-1:0];
               frame_pos = 0;
            end else if (paddr[2] == swm_pkg::REG_WINDOW_TYPE) begin
               if (prdata !== 32'(window_shape)) begin
                  mismatches++;
                  $error("window_type readback: expected %0d, got %0d", window_shape, prdata);
               end
            end else if (prdata !== 32'(frame_len_reg)) begin
               mismatches++;
               $error("frame_length readback: expected %0d, got %0d", frame_len_reg, prdata);
            end
         end

         // result word against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               $error("rsp word with nothing expected: windowed_sample %0d, last_in_frame %0d",
                      rsp_windowed_sample, rsp_last_in_frame);
            end else begin
               head_word = expected_words.pop_front();
               if (rsp_windowed_sample !== head_word.windowed) begin
                  mismatches++;
                  $error("windowed_sample: expected %0d, got %0d",
                         head_word.windowed, rsp_windowed_sample);
               end
               if (rsp_last_in_frame !== head_word.last) begin
                  mismatches++;
                  $error("last_in_frame: expected %0d, got %0d",
                         head_word.last, rsp_last_in_frame);
               end
            end
         end

         // accepted sample: clamp the length, scale, round, saturate
         if (req_valid && !req_stall) begin
            eff_len = 32'(frame_len_reg);
            if (eff_len < 2) eff_len = 2;
            if (eff_len > MAX_FRAME) eff_len = MAX_FRAME;
            if (frame_pos >= eff_len) frame_pos = 0;
            coef = window_coef(window_shape, frame_pos, eff_len);
            prod = (longint'(req_sample) * longint'(coef) + ROUND_HALF) >>> CF;
            if (prod > SAT_HI) prod = SAT_HI;
            if (prod < SAT_LO) prod = SAT_LO;
            head_word.windowed = prod[SAMPLE_BITS-1:0];
            head_word.last = (frame_pos == eff_len - 1);
            frame_pos = head_word.last ? 0 : frame_pos + 1;
            expected_words.push_back(head_word);
         end
      end
      pending <= expected_words.size();
      fail_count <= mismatches;
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for spectral_window_multiply_unit: clock, reset, sample words and register
// writes with random idling. Depends on swm_pkg and swm_window_checker.
module tb;

   localparam int FRAME_MAX = 1024;
   localparam int SB = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PIPE_DEPTH = 3;
   localparam int BACKLOG_CYCLES = 96;
   localparam int RANDOM_PHASES = 16;
   localparam logic [1:0] WIN_UNUSED = 2'd3;
   localparam logic signed [SB-1:0] S_MAX = 16'sh7FFF;
   localparam logic signed [SB-1:0] S_MIN = 16'sh8000;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [SB-1:0]              req_sample;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [SB-1:0]              rsp_windowed_sample;
   logic                              rsp_last_in_frame;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [swm_pkg::CSR_ADDR_W-1:0]    paddr;
   logic [swm_pkg::CSR_DATA_W-1:0]    pwdata;
   logic [swm_pkg::CSR_DATA_W-1:0]    prdata;
   logic                              pready;
   int                                pending;
   int                                fail_count;
   bit                                tx_burst;
   bit                                rx_burst;
   bit                                backlog_req;
   longint                            cycles = 0;

   spectral_window_multiply_unit #(
      .MAX_FRAME   (FRAME_MAX),
      .SAMPLE_BITS (SB)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_windowed_sample (rsp_windowed_sample),
      .rsp_last_in_frame   (rsp_last_in_frame),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   swm_window_checker #(
      .MAX_FRAME   (FRAME_MAX),
      .SAMPLE_BITS (SB)
   ) u_window_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_windowed_sample (rsp_windowed_sample),
      .rsp_last_in_frame   (rsp_last_in_frame),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready),
      .pending             (pending),
      .fail_count          (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL spectral_window_multiply_unit");
         $finish;
      end
   end

   // one sample word, after a random gap; returns at the accepting edge
   task automatic offer_sample(input logic signed [SB-1:0] value);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // register write once idle, then read it back
   task automatic reprogram(input logic sel, input logic [31:0] value);
      await_drain();
      repeat (PIPE_DEPTH + 1) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SB-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return 16'sd0;
         3:       return -16'sd1;
         default: return SB'($urandom);
      endcase
   endfunction

   // mostly short frames; a few medium, a few below the legal minimum
   function automatic logic [31:0] short_len();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return $urandom_range(0, 1);
      if (pick < 5) return $urandom_range(33, 200);
      return $urandom_range(2, 32);
   endfunction

   // result side: random stalls, one long hold-off when asked
   initial begin
      int hold;
      int results_seen;
      bit backlog_done;
      rsp_stall = 1'b0;
      rx_burst = 1'b0;
      results_seen = 0;
      backlog_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (backlog_req && !backlog_done) begin
            backlog_done = 1'b1;
            hold = BACKLOG_CYCLES;
         end else begin
            hold = rx_burst ? 0 : $urandom_range(0, 11);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         if (results_seen % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      int n_words;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      tx_burst = 1'b0;
      backlog_req = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // length 0 acts as 2: wrap and last flag every other word
      reprogram(swm_pkg::REG_FRAME_LENGTH, 32'd0);
      offer_sample(S_MAX);
      offer_sample(S_MIN);
      offer_sample(16'sd0);
      // unused window code behaves as rectangular
      reprogram(swm_pkg::REG_WINDOW_TYPE, 32'(WIN_UNUSED));
      offer_sample(16'sd1);
      offer_sample(-16'sd1);
      reprogram(swm_pkg::REG_WINDOW_TYPE, 32'(swm_pkg::WIN_HAMMING));
      offer_sample(S_MAX);
      offer_sample(S_MIN);
      reprogram(swm_pkg::REG_FRAME_LENGTH, 32'd5);
      offer_sample(S_MAX);
      offer_sample(S_MIN);
      offer_sample(16'sd1);
      offer_sample(-16'sd1);
      offer_sample(16'sh4000);
      offer_sample(-16'sh4001);
      offer_sample(S_MAX);
      // Hann, then a write in mid-frame restarts the position
      reprogram(swm_pkg::REG_WINDOW_TYPE, 32'(swm_pkg::WIN_HANN));
      offer_sample(S_MAX);
      offer_sample(S_MAX);
      offer_sample(S_MIN);
      reprogram(swm_pkg::REG_FRAME_LENGTH, 32'd1);
      offer_sample(S_MIN);
      offer_sample(S_MAX);
      offer_sample(16'sh5555);
      // all-ones length clamps to the maximum frame
      reprogram(swm_pkg::REG_FRAME_LENGTH, swm_pkg::LEN_MAX);
      offer_sample(16'sh2AAA);
      offer_sample(S_MAX);
      offer_sample(S_MIN);

      // random phases; long frames only with a cheap write right after
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0, 5, 12: reprogram(swm_pkg::REG_FRAME_LENGTH, short_len());
            3:        reprogram(swm_pkg::REG_WINDOW_TYPE, 32'(swm_pkg::WIN_HAMMING));
            4:        reprogram(swm_pkg::REG_FRAME_LENGTH, FRAME_MAX);
            10:       reprogram(swm_pkg::REG_WINDOW_TYPE, 32'(swm_pkg::WIN_HANN));
            11:       reprogram(swm_pkg::REG_FRAME_LENGTH, swm_pkg::LEN_MAX);
            default: begin
               if ($urandom_range(0, 1) == 1)
                  reprogram(swm_pkg::REG_WINDOW_TYPE, $urandom_range(0, 3));
               else
                  reprogram(swm_pkg::REG_FRAME_LENGTH, short_len());
            end
         endcase
         // phase 6 streams back to back into the long result hold-off
         tx_burst = (ph == 6) || ($urandom_range(0, 3) == 0);
         backlog_req = (ph == 6);
         n_words = $urandom_range(40, 66);
         for (int i = 0; i < n_words; i++) begin
            if (ph == 8 && i == n_words / 2) await_drain();
            offer_sample(pick_sample());
         end
      end

      await_drain();
      repeat (2 * PIPE_DEPTH + 2) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS spectral_window_multiply_unit");
      else
         $display("FAIL spectral_window_multiply_unit");
      $finish;
   end

endmodule
